// ===== rtl/isp_pkg.sv =====
// ----------------------------------------------------------------------------
// isp_pkg
// Shared types, character codes and precedence helpers for the infix to
// postfix converter.
// ----------------------------------------------------------------------------
package isp_pkg;

    localparam int ISP_STACK_DEPTH = 32;
    localparam int ISP_CHAR_W      = 8;
    localparam int ISP_OUT_DATA_W  = 16;

    localparam logic [ISP_CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [ISP_CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [ISP_CHAR_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [ISP_CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [ISP_CHAR_W-1:0] CH_CARET = 8'h5E;
    localparam logic [ISP_CHAR_W-1:0] CH_LPAR  = 8'h28;
    localparam logic [ISP_CHAR_W-1:0] CH_RPAR  = 8'h29;
    localparam logic [ISP_CHAR_W-1:0] CH_NUL   = 8'h00;

    typedef logic [ISP_CHAR_W-1:0] t_char;
    typedef logic [1:0]            t_prec;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_TAIL
    } t_state;

    typedef enum logic [2:0] {
        CLS_OPERAND,
        CLS_OPER,
        CLS_LPAR,
        CLS_RPAR,
        CLS_OTHER
    } t_chr_cls;

    typedef struct packed {
        logic push;
        logic pop;
    } t_stk_cmd;

    typedef struct packed {
        logic has_top;
        logic full;
    } t_stk_sts;

    typedef struct packed {
        logic emit;
        logic drop;
    } t_pop_dec;

    function automatic t_prec char_prec(input t_char c);
        t_prec p;
        p = 2'd0;
        if (c == CH_PLUS || c == CH_MINUS) p = 2'd1;
        if (c == CH_STAR || c == CH_SLASH) p = 2'd2;
        if (c == CH_CARET)                 p = 2'd3;
        return p;
    endfunction

    function automatic t_chr_cls char_class(input t_char c);
        t_chr_cls k;
        k = CLS_OTHER;
        if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
            (c >= 8'h30 && c <= 8'h39))
            k = CLS_OPERAND;
        else if (char_prec(c) != 2'd0)
            k = CLS_OPER;
        else if (c == CH_LPAR)
            k = CLS_LPAR;
        else if (c == CH_RPAR)
            k = CLS_RPAR;
        return k;
    endfunction

endpackage

// ===== rtl/isp_stack.sv =====
// ----------------------------------------------------------------------------
// isp_stack
// Operator stack: single-port memory with a registered top-of-stack read
// and a fill count. A push forwards its data to the top register.
// ----------------------------------------------------------------------------
module isp_stack #(
    parameter int DEPTH = isp_pkg::ISP_STACK_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  isp_pkg::t_stk_cmd i_cmd,
    input  isp_pkg::t_char    i_wdata,
    output isp_pkg::t_char    o_top,
    output isp_pkg::t_stk_sts o_sts
);
    import isp_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);

    t_char          r_mem [DEPTH];
    t_char          r_top;
    logic [CW-1:0]  r_count;
    logic [CW-1:0]  n_count;
    logic [CW-1:0]  w_rd_cnt;
    logic [AW-1:0]  w_rd_addr;
    logic           w_full;
    logic           w_wr;

    assign w_full    = (r_count == CW'(DEPTH));
    assign w_wr      = i_cmd.push && !w_full;
    assign w_rd_cnt  = i_cmd.pop ? (r_count - CW'(2)) : (r_count - CW'(1));
    assign w_rd_addr = w_rd_cnt[AW-1:0];

    always_comb begin
        n_count = r_count;
        if (w_wr) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_count[AW-1:0]] <= i_wdata;
            r_top                  <= i_wdata;
        end else begin
            r_top <= r_mem[w_rd_addr];
        end
    end

    assign o_top         = r_top;
    assign o_sts.has_top = (r_count != '0);
    assign o_sts.full    = w_full;

endmodule

// ===== rtl/isp_cmp.sv =====
// ----------------------------------------------------------------------------
// isp_cmp
// Pop decision unit: compares the stack top against the current character
// for operator precedence, closing parenthesis and end flush.
// ----------------------------------------------------------------------------
module isp_cmp (
    input  isp_pkg::t_char    i_cur,
    input  isp_pkg::t_char    i_top,
    input  logic              i_has_top,
    input  logic              i_flush,
    output isp_pkg::t_pop_dec o_dec
);
    import isp_pkg::*;

    t_chr_cls w_cls;
    logic     w_top_lpar;
    logic     w_prec_ge;

    assign w_cls      = char_class(i_cur);
    assign w_top_lpar = (i_top == CH_LPAR);
    assign w_prec_ge  = (char_prec(i_top) >= char_prec(i_cur));

    always_comb begin
        o_dec = '0;
        if (i_has_top) begin
            if (i_flush) begin
                o_dec.emit = 1'b1;
            end else begin
                case (w_cls)
                    CLS_OPER: begin
                        o_dec.emit = w_prec_ge;
                    end
                    CLS_RPAR: begin
                        o_dec.emit = !w_top_lpar;
                        o_dec.drop = w_top_lpar;
                    end
                    default: begin
                        o_dec = '0;
                    end
                endcase
            end
        end
    end

endmodule

// ===== rtl/infix_to_postfix_converter.sv =====
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard conversion of an infix character stream into postfix, one
// stack operation per cycle unless stalled, via a shared pop decision unit.
// ----------------------------------------------------------------------------
// Input: a new beat is accepted only after the previous beat is fully
// processed; a final beat also pops the whole stack, one entry a cycle
// while the output is not stalled.
// Reset: synchronous, active low; empties the stack and clears the overflow
// flag. Stack storage is not cleared.
module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = isp_pkg::ISP_STACK_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [isp_pkg::ISP_CHAR_W-1:0]     s_axis_tdata,   // [7:0] in_char
    input  logic                               s_axis_tlast,   // expr_last
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [7:0] out_char, [8] expr_end, [9] overflow, [15:10] zero
    output logic [isp_pkg::ISP_OUT_DATA_W-1:0] m_axis_tdata,
    output logic                               m_axis_tlast,   // last_of_run
    output logic                               m_axis_tuser    // char_valid
);
    import isp_pkg::*;

    t_state   r_state, n_state;
    t_char    r_char;
    logic     r_last;
    logic     r_pnd_valid;
    t_char    r_pnd_char;
    logic     r_out_valid;
    t_char    r_out_char;
    logic     r_out_cv;
    logic     r_out_lor;
    logic     r_out_end;
    logic     r_out_ovf;
    logic     r_ovf_seen;

    t_stk_cmd w_cmd;
    t_stk_sts w_sts;
    t_pop_dec w_dec;
    t_char    w_top;
    t_chr_cls w_cls;
    logic     w_out_ok;
    logic     w_emit_ok;
    logic     w_emit;
    t_char    w_emit_char;
    logic     w_fin;
    logic     w_fin_fire;
    logic     w_emit_fire;
    logic     w_fin_load;
    logic     w_out_load;
    logic     w_accept;

    isp_stack #(
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_wdata (r_char),
        .o_top   (w_top),
        .o_sts   (w_sts)
    );

    isp_cmp u_cmp (
        .i_cur     (r_char),
        .i_top     (w_top),
        .i_has_top (w_sts.has_top),
        .i_flush   (r_state == ST_TAIL),
        .o_dec     (w_dec)
    );

    assign w_cls       = char_class(r_char);
    assign w_out_ok    = !r_out_valid || m_axis_tready;
    assign w_emit_ok   = !r_pnd_valid || w_out_ok;
    assign w_accept    = s_axis_tvalid && s_axis_tready;
    assign w_emit_fire = w_emit && w_emit_ok;
    assign w_fin_load  = r_pnd_valid || r_last;
    assign w_fin_fire  = w_fin && (w_out_ok || !w_fin_load);
    assign w_out_load  = (w_emit_fire && r_pnd_valid) || (w_fin_fire && w_fin_load);

    always_comb begin
        s_axis_tready = 1'b0;
        w_emit        = 1'b0;
        w_emit_char   = w_top;
        w_fin         = 1'b0;
        w_cmd         = '0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
            end
            ST_EVAL: begin
                case (w_cls)
                    CLS_OPERAND: begin
                        w_emit      = 1'b1;
                        w_emit_char = r_char;
                    end
                    CLS_OPER, CLS_RPAR: begin
                        if (w_dec.emit) begin
                            w_emit    = 1'b1;
                            w_cmd.pop = w_emit_ok;
                        end else if (w_dec.drop) begin
                            w_cmd.pop = 1'b1;
                        end else begin
                            w_cmd.push = (w_cls == CLS_OPER);
                        end
                    end
                    CLS_LPAR: begin
                        w_cmd.push = 1'b1;
                    end
                    default: begin
                        w_emit = 1'b0;
                    end
                endcase
            end
            ST_TAIL: begin
                if (r_last && w_dec.emit) begin
                    w_emit    = 1'b1;
                    w_cmd.pop = w_emit_ok;
                end else begin
                    w_fin = 1'b1;
                end
            end
            default: begin
                w_fin = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) n_state = ST_EVAL;
            end
            ST_EVAL: begin
                case (w_cls)
                    CLS_OPERAND: begin
                        if (w_emit_ok) n_state = ST_TAIL;
                    end
                    CLS_OPER, CLS_RPAR: begin
                        if (!w_dec.emit) n_state = ST_TAIL;
                    end
                    default: begin
                        n_state = ST_TAIL;
                    end
                endcase
            end
            ST_TAIL: begin
                if (w_fin_fire) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pnd_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_ovf_seen  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_emit_fire) begin
                r_pnd_valid <= 1'b1;
            end else if (w_fin_fire) begin
                r_pnd_valid <= 1'b0;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_cmd.push && w_sts.full) begin
                r_ovf_seen <= 1'b1;
            end else if (w_fin_fire && r_last) begin
                r_ovf_seen <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_char <= s_axis_tdata;
            r_last <= s_axis_tlast;
        end
        if (w_emit_fire) begin
            r_pnd_char <= w_emit_char;
        end
        if (w_emit_fire && r_pnd_valid) begin
            r_out_char <= r_pnd_char;
            r_out_cv   <= 1'b1;
            r_out_lor  <= 1'b0;
            r_out_end  <= 1'b0;
            r_out_ovf  <= 1'b0;
        end else if (w_fin_fire && w_fin_load) begin
            r_out_char <= r_pnd_valid ? r_pnd_char : CH_NUL;
            r_out_cv   <= r_pnd_valid;
            r_out_lor  <= 1'b1;
            r_out_end  <= r_last;
            r_out_ovf  <= r_last && r_ovf_seen;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(ISP_OUT_DATA_W - ISP_CHAR_W - 2){1'b0}},
                            r_out_ovf, r_out_end, r_out_char};
    assign m_axis_tlast  = r_out_lor;
    assign m_axis_tuser  = r_out_cv;

`ifndef SYNTHESIS
    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !r_pnd_valid)
        else $error("pending result left over between beats");

    a_no_push_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.push && w_cmd.pop))
        else $error("stack push and pop in one cycle");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.pop |-> w_sts.has_top)
        else $error("pop from empty stack");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |-> (!r_out_valid || m_axis_tready))
        else $error("output register overwritten while held");

    a_ovf_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_ovf) |-> (r_out_end && r_out_lor))
        else $error("overflow flag outside expression end");
`endif

endmodule
